// ----- rtl/phase_ramp_rgb565_gradient_assert.svh -----
// assertion macros for the phase ramp gradient block
`ifndef PHASE_RAMP_RGB565_GRADIENT_ASSERT_SVH
`define PHASE_RAMP_RGB565_GRADIENT_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define PRGG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define PRGG_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- rtl/prgg_pkg.sv -----
// shared types and constants for the phase ramp gradient block
package prgg_pkg;

   localparam int PHASE_W   = 18;
   localparam int FRAC_W    = 16;
   localparam int MS_W      = 10;
   localparam int STEP_W    = 16;
   localparam int PAL_W     = 64;
   localparam int COLOR_W   = 16;
   localparam int NIGHT_W   = 8;
   localparam int CSR_IDX_W = 2;
   localparam int MUL_A_W   = 18;
   localparam int MUL_B_W   = 16;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;

   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP    = 2'd1;

   localparam logic [STEP_W-1:0]  STEP_RESET = 16'd20;
   localparam logic [MUL_B_W-1:0] MUL_255    = 16'd255;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_DELTA  = 10'b00_0000_0010,
      S_UPDATE = 10'b00_0000_0100,
      S_MIX    = 10'b00_0000_1000,
      S_NIGHT  = 10'b00_0001_0000,
      S_NDIV   = 10'b00_0010_0000,
      S_RED    = 10'b00_0100_0000,
      S_GREEN  = 10'b00_1000_0000,
      S_BLUE   = 10'b01_0000_0000,
      S_DONE   = 10'b10_0000_0000
   } state_type;

endpackage

// ----- rtl/phase_ramp_rgb565_gradient.sv -----
// top level of the phase ramp rgb565 gradient block
//
// each tick word moves a q.16 phase up or down by step_per_ms * elapsed_ms, saturating
// between zero and the last stage, and returns one word with the rgb565 blend of the two
// neighboring palette stages and a 0..255 night progress. one 18x16 multiplier is shared
// under a one-hot sequencer and used seven times per tick (delta, mix, night scale, night
// divide, red, green, blue), so a tick steps through all of these before its result word
// is loaded, and req_ready is low from acceptance until the sequencer is idle again. the
// result sits in an output register, so the next tick is taken while it waits; a tick
// finishing while the old result is still unread holds in its last step. csr writes are
// taken every cycle and must only be issued while idle. csr index 0 is the palette (stage
// 0 in the low bits), index 1 is step_per_ms, other indexes are dropped.
module phase_ramp_rgb565_gradient #(
   parameter int STAGES = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   // tick channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_toward_night,
   input  logic [prgg_pkg::MS_W-1:0]         req_elapsed_ms,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [prgg_pkg::COLOR_W-1:0]      rsp_blend_color,
   output logic [prgg_pkg::NIGHT_W-1:0]      rsp_night_mix,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [prgg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [prgg_pkg::PAL_W-1:0]        csr_wdata
);

   import prgg_pkg::*;

   // phase bound and night scaling constants
   localparam logic [PHASE_W-1:0] PhaseMax   = PHASE_W'((STAGES - 1) * 65536);
   localparam logic [25:0]        NightHalf  = 26'((STAGES - 1) * 32768);
   localparam logic [MUL_B_W-1:0] NightRecip = MUL_B_W'((4096 + STAGES - 2) / (STAGES - 1));
   localparam int                 LastStage  = STAGES - 1;

   // control state
   state_type            state_ff, state_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [PAL_W-1:0]     palette_ff;
   logic [STEP_W-1:0]    step_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   // working registers of one tick
   logic                 up_ff;
   logic [MS_W-1:0]      ms_ff;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [7:0]           mix_ff, mix_in;
   logic [NIGHT_W-1:0]   night_ff, night_in;
   logic [4:0]           red_ff;
   logic [5:0]           green_ff;
   logic [COLOR_W-1:0]   rsp_color_ff;
   logic [NIGHT_W-1:0]   rsp_night_ff;

   // shared multiplier operands
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;

   // palette lookup for the current phase
   logic [1:0]           stage;
   logic [COLOR_W-1:0]   color_lo, color_hi, color_last, color_edge;
   logic                 edge_case;
   logic [5:0]           chan_a   [3];
   logic [5:0]           chan_b   [3];
   logic                 chan_neg [3];
   logic [5:0]           chan_mag [3];

   // phase update
   logic [25:0]          delta;
   logic [26:0]          up_sum;
   logic [25:0]          night_sum;
   logic [9:0]           night_div;
   logic                 finish;

   assign req_ready       = (state_ff == S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_blend_color = rsp_color_ff;
   assign rsp_night_mix   = rsp_night_ff;

   // truncating blend step: a + sign * floor(|b-a|*mix / 255)
   function automatic logic [5:0] chan_blend(input logic [5:0] a, input logic neg,
                                             input logic [13:0] p);
      logic [13:0] q_sum;
      logic [5:0]  q;
      q_sum = p + 14'd1 + {8'd0, p[13:8]};
      q     = q_sum[13:8];
      return neg ? (a - q) : (a + q);
   endfunction

   assign stage      = phase_ff[PHASE_W-1:FRAC_W];
   assign color_lo   = palette_ff[{stage, 4'b0000} +: COLOR_W];
   assign color_hi   = palette_ff[{2'(stage + 2'd1), 4'b0000} +: COLOR_W];
   assign color_last = palette_ff[LastStage*COLOR_W +: COLOR_W];
   // phase zero and the top stage return a palette entry unblended
   assign edge_case  = (phase_ff == '0) || (32'(stage) >= 32'(LastStage));
   assign color_edge = (phase_ff == '0) ? palette_ff[COLOR_W-1:0] : color_last;

   // per-channel endpoints, red green blue in lanes 0..2
   always_comb begin
      chan_a[0] = {1'b0, color_lo[15:11]};
      chan_b[0] = {1'b0, color_hi[15:11]};
      chan_a[1] = color_lo[10:5];
      chan_b[1] = color_hi[10:5];
      chan_a[2] = {1'b0, color_lo[4:0]};
      chan_b[2] = {1'b0, color_hi[4:0]};
      for (int i = 0; i < 3; i++) begin
         chan_neg[i] = chan_b[i] < chan_a[i];
         chan_mag[i] = chan_neg[i] ? (chan_a[i] - chan_b[i]) : (chan_b[i] - chan_a[i]);
      end
   end

   // saturating phase update from the registered delta
   assign delta     = prod_ff[25:0];
   assign up_sum    = {9'd0, phase_ff} + {1'b0, delta};
   assign night_sum = prod_ff[25:0] + NightHalf;
   assign night_div = prod_ff[21:12];
   assign finish    = !rsp_valid_ff || rsp_ready;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_DELTA: begin
            mul_a = MUL_A_W'(step_ff);
            mul_b = MUL_B_W'(ms_ff);
         end
         S_MIX: begin
            mul_a = MUL_A_W'(phase_ff[FRAC_W-1:0]);
            mul_b = MUL_255;
         end
         S_NIGHT: begin
            mul_a = phase_ff;
            mul_b = MUL_255;
         end
         S_NDIV: begin
            // phase*255 / 65536 with a rounding offset, then divided by STAGES - 1
            mul_a = MUL_A_W'(night_sum[25:16]);
            mul_b = NightRecip;
         end
         S_RED: begin
            mul_a = MUL_A_W'(chan_mag[0]);
            mul_b = MUL_B_W'(mix_ff);
         end
         S_GREEN: begin
            mul_a = MUL_A_W'(chan_mag[1]);
            mul_b = MUL_B_W'(mix_ff);
         end
         S_BLUE, S_DONE: begin
            // blue product stays in place while the result waits
            mul_a = MUL_A_W'(chan_mag[2]);
            mul_b = MUL_B_W'(mix_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      mix_in       = mix_ff;
      night_in     = night_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DELTA;
            end
         end
         S_DELTA: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (up_ff) begin
               phase_in = (up_sum > {9'd0, PhaseMax}) ? PhaseMax : up_sum[PHASE_W-1:0];
            end else begin
               phase_in = (delta >= 26'(phase_ff)) ? '0 : (phase_ff - delta[PHASE_W-1:0]);
            end
            state_in = S_MIX;
         end
         S_MIX: begin
            state_in = S_NIGHT;
         end
         S_NIGHT: begin
            // round half up of frac*255 / 65536
            mix_in   = 8'((prod_ff[23:0] + 24'd32768) >> 16);
            state_in = S_NDIV;
         end
         S_NDIV: begin
            state_in = S_RED;
         end
         S_RED: begin
            night_in = (night_div > 10'd255) ? 8'd255 : night_div[7:0];
            state_in = S_GREEN;
         end
         S_GREEN: begin
            state_in = S_BLUE;
         end
         S_BLUE: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold here until the output register is free
            if (finish) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         palette_ff   <= '0;
         step_ff      <= STEP_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PALETTE: palette_ff <= csr_wdata;
               CSR_STEP:    step_ff    <= csr_wdata[STEP_W-1:0];
               default:     ;
            endcase
         end
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mix_ff   <= mix_in;
      night_ff <= night_in;
      if (req_valid && req_ready) begin
         up_ff <= req_toward_night;
         ms_ff <= req_elapsed_ms;
      end
      if (state_ff == S_GREEN) begin
         red_ff <= 5'(chan_blend(chan_a[0], chan_neg[0], prod_ff[13:0]));
      end
      if (state_ff == S_BLUE) begin
         green_ff <= chan_blend(chan_a[1], chan_neg[1], prod_ff[13:0]);
      end
      if (state_ff == S_DONE && finish) begin
         rsp_night_ff <= night_ff;
         rsp_color_ff <= edge_case ? color_edge
                       : {red_ff, green_ff,
                          5'(chan_blend(chan_a[2], chan_neg[2], prod_ff[13:0]))};
      end
   end

   // checks on the sequencer and the phase bound
`include "phase_ramp_rgb565_gradient_assert.svh"

   `PRGG_ASSERT_SAME(a_phase_bound, 1'b1, phase_ff <= PhaseMax, "phase above last stage")
   `PRGG_ASSERT_SAME(a_state_onehot, 1'b1, $onehot(state_ff), "sequencer state not one-hot")
   `PRGG_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_ff == S_DELTA,
                     "tick not started")
   `PRGG_ASSERT_NEXT(a_done_loads, state_ff == S_DONE && finish, rsp_valid && req_ready,
                     "result not loaded")

endmodule
